// ===== hw/rtl/cocu_pkg.sv =====
// Shared types, constants and saturating helpers for the column owner
// communication update block. No dependencies.
package cocu_pkg;

    localparam int ID_W        = 4;
    localparam int COL_W       = 20;
    localparam int CNT_W       = 32;
    localparam int LIST_CAP    = 16;
    localparam int LIST_IDX_W  = 4;
    localparam int LEN_W       = 5;
    localparam int COST_W      = CNT_W + 1;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 120;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        ACT_GREEDY = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GREEDY,
        ST_GDRAIN,
        ST_UPDATE,
        ST_OWNER,
        ST_OWRITE,
        ST_RESULT
    } back_state_t;

    // One complete column as handed from the front to the back.
    typedef struct packed {
        action_t                               action;
        logic [COL_W-1:0]                      column;
        logic [ID_W-1:0]                       owner;
        logic [LEN_W-1:0]                      len;
        logic [LIST_CAP-1:0][ID_W-1:0]         ids;
    } job_t;

    typedef struct packed {
        logic [CNT_W-1:0] elements;
        logic [CNT_W-1:0] receives;
        logic [CNT_W-1:0] sends;
    } cnt_word_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W+1-LEN_W){1'b0}}, b};
        sat_add = s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
        logic [CNT_W-1:0] bx;
        bx = {{(CNT_W-LEN_W){1'b0}}, b};
        sat_sub = (a > bx) ? (a - bx) : '0;
    endfunction

endpackage

// ===== hw/rtl/cocu_front.sv =====
// Front end: collects the processor entries of a column and hands the
// finished column to the queue. Depends on cocu_pkg.
module cocu_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: column [19:0], owner [23:20], proc_id [27:24], zero fill above
    input  logic [cocu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: action [1:0]
    input  logic [cocu_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  logic                                s_axis_tlast,
    input  logic                                q_full,
    output logic                                q_push,
    output cocu_pkg::job_t                      q_job
);

    logic [cocu_pkg::LIST_CAP-1:0][cocu_pkg::ID_W-1:0] list_reg, list_next;
    logic [cocu_pkg::LEN_W-1:0]                        len_reg, len_next;
    logic [cocu_pkg::LIST_CAP-1:0][cocu_pkg::ID_W-1:0] ids_cur;
    logic [cocu_pkg::LEN_W-1:0]                        len_cur;
    logic                                              accept;
    cocu_pkg::action_t                                 action;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = cocu_pkg::action_t'(s_axis_tuser);

    always_comb
    begin
        ids_cur = list_reg;
        len_cur = len_reg;
        // Entries beyond the list capacity are dropped.
        if (len_reg < cocu_pkg::LEN_W'(cocu_pkg::LIST_CAP))
        begin
            ids_cur[len_reg[cocu_pkg::LIST_IDX_W-1:0]] = s_axis_tdata[27:24];
            len_cur = len_reg + 1'b1;
        end
    end

    always_comb
    begin
        list_next = list_reg;
        len_next  = len_reg;
        q_push    = 1'b0;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                len_next = '0;
                q_push   = (action != cocu_pkg::ACT_NONE);
            end
            else
            begin
                list_next = ids_cur;
                len_next  = len_cur;
            end
        end
    end

    always_comb
    begin
        q_job.action = action;
        q_job.column = s_axis_tdata[19:0];
        q_job.owner  = s_axis_tdata[23:20];
        q_job.len    = len_cur;
        q_job.ids    = ids_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

endmodule

// ===== hw/rtl/cocu_queue.sv =====
// Two-entry queue of complete columns between front and back.
// Depends on cocu_pkg.
module cocu_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cocu_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output cocu_pkg::job_t pop_job,
    output logic           not_empty
);

    cocu_pkg::job_t               entry_reg [cocu_pkg::QUEUE_DEPTH];
    logic [cocu_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cocu_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cocu_pkg::QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [cocu_pkg::QCNT_W-1:0] QCNT_one(input logic b);
        QCNT_one = {{(cocu_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign full      = (count_reg == cocu_pkg::QCNT_W'(cocu_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_one(push) - QCNT_one(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("column queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("column queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cocu_pkg::QCNT_W'(cocu_pkg::QUEUE_DEPTH))
        else $error("column queue count out of range");

endmodule

// ===== hw/rtl/cocu_back.sv =====
// Back end: greedy owner search and counter update over the per-processor
// counter memory, plus the result register. Depends on cocu_pkg.
module cocu_back
#(
    parameter int PROCS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  cocu_pkg::job_t                      q_job,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cocu_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int IW = $clog2(PROCS);

    cocu_pkg::back_state_t            state_reg, state_next;
    cocu_pkg::job_t                   job_reg;
    logic [cocu_pkg::ID_W-1:0]        q_reg;
    logic [cocu_pkg::LEN_W-1:0]       idx_reg;

    // Counter memory with one valid bit per processor; unwritten reads zero.
    cocu_pkg::cnt_word_t              mem [PROCS];
    logic [PROCS-1:0]                 valid_reg;
    cocu_pkg::cnt_word_t              rd_q_reg;
    logic                             rd_ok_reg;
    cocu_pkg::cnt_word_t              rd_word;
    logic [IW-1:0]                    rd_addr;
    logic                             wr_en;
    logic [IW-1:0]                    wr_addr;
    cocu_pkg::cnt_word_t              wr_data;

    // Greedy pipeline: read, cost terms, cost, compare.
    logic                             p1_act_reg, p1_cand_reg;
    logic [cocu_pkg::ID_W-1:0]        p1_id_reg;
    logic [cocu_pkg::LEN_W-1:0]       p1_k_reg;
    logic                             p2_act_reg, p2_cand_reg;
    logic [cocu_pkg::ID_W-1:0]        p2_id_reg;
    logic [cocu_pkg::COST_W-1:0]      p2_cs_reg, p2_cr_reg;
    logic                             p3_act_reg, p3_cand_reg;
    logic [cocu_pkg::ID_W-1:0]        p3_id_reg;
    logic [cocu_pkg::COST_W-1:0]      p3_cost_reg;
    logic                             found_reg;
    logic [cocu_pkg::ID_W-1:0]        best_reg;
    logic [cocu_pkg::COST_W-1:0]      best_cost_reg;

    // Receive update stage: the read issued last cycle is written back now.
    logic                             u1_vld_reg;
    logic [IW-1:0]                    u1_addr_reg;
    logic [cocu_pkg::LEN_W-1:0]       u1_k_reg;

    logic [cocu_pkg::CNT_W-1:0]       res_send_reg, res_recv_reg, res_elem_reg;
    logic                             out_vld_reg;
    logic [cocu_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic [cocu_pkg::ID_W-1:0]        cur_id;
    logic                             cur_in, q_in, cur_earlier, q_listed, do_add;
    logic [cocu_pkg::LEN_W-1:0]       match_cnt, amount;
    logic                             issue_g, issue_u, load_out, last_idx;

    assign cur_id   = job_reg.ids[idx_reg[cocu_pkg::LIST_IDX_W-1:0]];
    assign cur_in   = (32'(cur_id) < 32'(PROCS));
    assign q_in     = (32'(q_reg) < 32'(PROCS));
    assign do_add   = (job_reg.action != cocu_pkg::ACT_REMOVE);
    assign last_idx = (idx_reg == job_reg.len - 1'b1);
    assign rd_word  = rd_ok_reg ? rd_q_reg : '0;
    assign amount   = q_listed ? job_reg.len - 1'b1 : job_reg.len;

    always_comb
    begin
        match_cnt   = '0;
        cur_earlier = 1'b0;
        q_listed    = 1'b0;
        for (int j = 0; j < cocu_pkg::LIST_CAP; j++)
        begin
            if (cocu_pkg::LEN_W'(j) < job_reg.len)
            begin
                if (job_reg.ids[j] == cur_id)
                begin
                    match_cnt = match_cnt + 1'b1;
                end
                if (job_reg.ids[j] == q_reg)
                begin
                    q_listed = 1'b1;
                end
            end
            if ((cocu_pkg::LEN_W'(j) < idx_reg) && (job_reg.ids[j] == cur_id))
            begin
                cur_earlier = 1'b1;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cocu_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_job.action == cocu_pkg::ACT_GREEDY) ?
                                 cocu_pkg::ST_GREEDY : cocu_pkg::ST_UPDATE;
                end
            end
            cocu_pkg::ST_GREEDY:
            begin
                if (last_idx)
                begin
                    state_next = cocu_pkg::ST_GDRAIN;
                end
            end
            cocu_pkg::ST_GDRAIN:
            begin
                if (!p1_act_reg && !p2_act_reg && !p3_act_reg)
                begin
                    state_next = cocu_pkg::ST_UPDATE;
                end
            end
            cocu_pkg::ST_UPDATE:
            begin
                if (last_idx)
                begin
                    state_next = cocu_pkg::ST_OWNER;
                end
            end
            cocu_pkg::ST_OWNER:  state_next = cocu_pkg::ST_OWRITE;
            cocu_pkg::ST_OWRITE: state_next = cocu_pkg::ST_RESULT;
            cocu_pkg::ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = cocu_pkg::ST_IDLE;
                end
            end
            default: state_next = cocu_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_pop    = 1'b0;
        issue_g  = 1'b0;
        issue_u  = 1'b0;
        load_out = 1'b0;
        rd_addr  = cur_in ? IW'(32'(cur_id)) : '0;
        case (state_reg)
            cocu_pkg::ST_IDLE:   q_pop = q_valid;
            cocu_pkg::ST_GREEDY: issue_g = 1'b1;
            cocu_pkg::ST_UPDATE:
            begin
                // Duplicates are folded into the first occurrence.
                issue_u = cur_in && !cur_earlier && (cur_id != q_reg);
            end
            cocu_pkg::ST_OWNER:  rd_addr = q_in ? IW'(32'(q_reg)) : '0;
            cocu_pkg::ST_RESULT: load_out = !out_vld_reg || m_axis_tready;
            default:             q_pop = 1'b0;
        endcase
    end

    // Write port: receive write-back, or the owner's own update.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = u1_addr_reg;
        wr_data = rd_word;
        if (u1_vld_reg)
        begin
            wr_en            = 1'b1;
            wr_data.receives = do_add ? cocu_pkg::sat_add(rd_word.receives, u1_k_reg)
                                      : cocu_pkg::sat_sub(rd_word.receives, u1_k_reg);
        end
        else if ((state_reg == cocu_pkg::ST_OWRITE) && q_in)
        begin
            wr_en            = 1'b1;
            wr_addr          = IW'(32'(q_reg));
            wr_data.sends    = do_add ? cocu_pkg::sat_add(rd_word.sends, amount)
                                      : cocu_pkg::sat_sub(rd_word.sends, amount);
            wr_data.elements = do_add ? cocu_pkg::sat_add(rd_word.elements, 5'd1)
                                      : cocu_pkg::sat_sub(rd_word.elements, 5'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cocu_pkg::ST_IDLE;
            p1_act_reg  <= 1'b0;
            p2_act_reg  <= 1'b0;
            p3_act_reg  <= 1'b0;
            u1_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_act_reg <= issue_g;
            p2_act_reg <= p1_act_reg;
            p3_act_reg <= p2_act_reg;
            u1_vld_reg <= issue_u;
            if (q_pop)
            begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else if ((state_reg == cocu_pkg::ST_GREEDY) ||
                     (state_reg == cocu_pkg::ST_UPDATE))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == cocu_pkg::ST_GDRAIN)
            begin
                idx_reg <= '0;
            end
            if (p3_act_reg && p3_cand_reg &&
                (!found_reg || (p3_cost_reg < best_cost_reg)))
            begin
                found_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
            q_reg   <= q_job.owner;
        end
        else if ((state_reg == cocu_pkg::ST_GDRAIN) && (state_next == cocu_pkg::ST_UPDATE))
        begin
            // With no candidate in range the first listed processor is named.
            q_reg <= found_reg ? best_reg : job_reg.ids[0];
        end

        p1_cand_reg <= issue_g && cur_in;
        p1_id_reg   <= cur_id;
        p1_k_reg    <= match_cnt;

        p2_cand_reg <= p1_cand_reg;
        p2_id_reg   <= p1_id_reg;
        p2_cs_reg   <= {1'b0, rd_word.sends}
                       + {{(cocu_pkg::COST_W-cocu_pkg::LEN_W){1'b0}}, job_reg.len}
                       - cocu_pkg::COST_W'(1);
        p2_cr_reg   <= {1'b0, rd_word.receives}
                       + {{(cocu_pkg::COST_W-cocu_pkg::LEN_W){1'b0}}, p1_k_reg}
                       - cocu_pkg::COST_W'(1);

        p3_cand_reg <= p2_cand_reg;
        p3_id_reg   <= p2_id_reg;
        p3_cost_reg <= (p2_cs_reg > p2_cr_reg) ? p2_cs_reg : p2_cr_reg;

        if (p3_act_reg && p3_cand_reg && (!found_reg || (p3_cost_reg < best_cost_reg)))
        begin
            best_reg      <= p3_id_reg;
            best_cost_reg <= p3_cost_reg;
        end

        u1_addr_reg <= rd_addr;
        u1_k_reg    <= match_cnt;

        if (state_reg == cocu_pkg::ST_OWRITE)
        begin
            res_send_reg <= q_in ? wr_data.sends : '0;
            res_recv_reg <= q_in ? rd_word.receives : '0;
            res_elem_reg <= q_in ? wr_data.elements : '0;
        end

        if (load_out)
        begin
            out_data_reg <= {res_elem_reg, res_recv_reg, res_send_reg,
                             q_reg, job_reg.column};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cocu_pkg::ST_IDLE) |->
            !(p1_act_reg || p2_act_reg || p3_act_reg || u1_vld_reg))
        else $error("counter pipeline busy while back end idle");

    a_owner_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cocu_pkg::ST_OWRITE) |-> !u1_vld_reg)
        else $error("receive write-back collides with owner update");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (32'(best_reg) < 32'(PROCS)))
        else $error("greedy choice outside the processor range");

endmodule

// ===== hw/rtl/column_owner_comm_update.sv =====
// Top level of the column owner communication update block.
// Depends on cocu_pkg, cocu_front, cocu_queue and cocu_back.
//
//  Channel  Dir  Payload
//  s_axis   in   tdata: column, owner, proc_id; tuser: action; tlast: last entry
//  m_axis   out  tdata: column_out, chosen_owner, owner_sends/receives/elements
//
// The front takes one processor entry per cycle while the queue is not full; the
// back walks the entries of each column over the counter memory through its single
// read port, twice for greedy (search, then update) and once for assign or remove.
// Reset clears the counter valid bits at once, so there is no clearing pass.
// A two-column queue lets the front keep taking entries while the back works;
// a held result stalls the back first and the input only once the queue fills.
module column_owner_comm_update
#(
    parameter int PROCS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: column [19:0], owner [23:20], proc_id [27:24], zero fill above
    input  logic [cocu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: action [1:0]
    input  logic [cocu_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: column_out [19:0], chosen_owner [23:20], owner_sends [55:24],
    //        owner_receives [87:56], owner_elements [119:88]
    output logic [cocu_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic           q_full, q_push, q_pop, q_not_empty;
    cocu_pkg::job_t push_job, pop_job;

    cocu_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    cocu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .not_empty (q_not_empty)
    );

    cocu_back #(.PROCS(PROCS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for column_owner_comm_update: drives processor lists per column,
// predicts the chosen owner and its counters, and checks every result transaction.
// Depends on cocu_pkg and the column_owner_comm_update RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int NPROC       = 16;
    localparam int ITEMS       = 1250;
    localparam int QUIET_ITEMS = 150;
    localparam int LIMIT       = 400000;
    localparam int DRAIN       = 100;
    localparam int MAX_REPORTS = 50;
    localparam int OWN_LSB     = cocu_pkg::COL_W;
    localparam int SEND_LSB    = cocu_pkg::COL_W + cocu_pkg::ID_W;
    localparam int RECV_LSB    = SEND_LSB + cocu_pkg::CNT_W;
    localparam int ELEM_LSB    = RECV_LSB + cocu_pkg::CNT_W;

    typedef struct {
        logic [cocu_pkg::COL_W-1:0] column;
        logic [cocu_pkg::ID_W-1:0]  owner;
        logic [cocu_pkg::CNT_W-1:0] sends;
        logic [cocu_pkg::CNT_W-1:0] receives;
        logic [cocu_pkg::CNT_W-1:0] elements;
    } owner_result_t;

    // Tracks the per-processor counters and the results the block owes us.
    // With four-bit identifiers and sixteen processors every listed id has counters.
    class owner_board_t;
        logic [cocu_pkg::CNT_W-1:0] sends    [NPROC];
        logic [cocu_pkg::CNT_W-1:0] receives [NPROC];
        logic [cocu_pkg::CNT_W-1:0] elements [NPROC];
        logic [cocu_pkg::ID_W-1:0]  ids      [cocu_pkg::LIST_CAP];
        int unsigned                len;
        owner_result_t              expected [$];
        int                         errors;
        int                         checked;

        function new();
            foreach (sends[i])
            begin
                sends[i]    = '0;
                receives[i] = '0;
                elements[i] = '0;
            end
            len     = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [cocu_pkg::CNT_W-1:0] bump(logic [cocu_pkg::CNT_W-1:0] v,
                                                   int unsigned amount, bit up);
            logic [cocu_pkg::CNT_W:0] s;
            if (up)
            begin
                s = {1'b0, v} + amount;
                return s[cocu_pkg::CNT_W] ? '1 : s[cocu_pkg::CNT_W-1:0];
            end
            return (v > amount) ? v - amount : '0;
        endfunction

        // Lowest max(sends + n - 1, receives + k - 1); the earliest entry keeps a tie.
        function logic [cocu_pkg::ID_W-1:0] pick_owner();
            logic [cocu_pkg::ID_W-1:0]  best;
            logic [cocu_pkg::CNT_W+1:0] by_send, by_recv, cost, best_cost;
            int unsigned                hits;
            int                         i, j;
            best      = ids[0];
            best_cost = '0;
            for (i = 0; i < len; i++)
            begin
                hits = 0;
                for (j = 0; j < len; j++)
                    if (ids[j] == ids[i])
                        hits++;
                by_send = sends[ids[i]] + len - 1;
                by_recv = receives[ids[i]] + hits - 1;
                cost    = (by_send > by_recv) ? by_send : by_recv;
                if (i == 0 || cost < best_cost)
                begin
                    best      = ids[i];
                    best_cost = cost;
                end
            end
            return best;
        endfunction

        function void settle(logic [cocu_pkg::ID_W-1:0] q, bit up);
            bit listed;
            int i;
            listed = 1'b0;
            for (i = 0; i < len; i++)
            begin
                if (ids[i] == q)
                    listed = 1'b1;
                else
                    receives[ids[i]] = bump(receives[ids[i]], 1, up);
            end
            sends[q]    = bump(sends[q], listed ? len - 1 : len, up);
            elements[q] = bump(elements[q], 1, up);
        endfunction

        function void note_entry(cocu_pkg::action_t act, logic [cocu_pkg::COL_W-1:0] col,
                                 logic [cocu_pkg::ID_W-1:0] own,
                                 logic [cocu_pkg::ID_W-1:0] pid, logic last);
            owner_result_t             res;
            logic [cocu_pkg::ID_W-1:0] q;
            // Entries beyond the list capacity are dropped.
            if (len < cocu_pkg::LIST_CAP)
            begin
                ids[len] = pid;
                len++;
            end
            if (!last)
                return;
            if (act == cocu_pkg::ACT_NONE)
            begin
                len = 0;
                return;
            end
            q = (act == cocu_pkg::ACT_GREEDY) ? pick_owner() : own;
            settle(q, act != cocu_pkg::ACT_REMOVE);
            len          = 0;
            res.column   = col;
            res.owner    = q;
            res.sends    = sends[q];
            res.receives = receives[q];
            res.elements = elements[q];
            expected.push_back(res);
        endfunction

        function void compare(string what, logic [cocu_pkg::COL_W-1:0] col,
                              logic [cocu_pkg::CNT_W-1:0] want,
                              logic [cocu_pkg::CNT_W-1:0] got);
            if (want !== got)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch for column %h: expected %h, got %h",
                             $time, what, col, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [cocu_pkg::OUT_DATA_W-1:0] data);
            owner_result_t want;
            if (expected.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, got %h", $time, data);
                errors++;
                return;
            end
            want = expected.pop_front();
            checked++;
            compare("column", want.column, want.column, data[cocu_pkg::COL_W-1:0]);
            compare("owner", want.column, want.owner, data[OWN_LSB +: cocu_pkg::ID_W]);
            compare("sends", want.column, want.sends, data[SEND_LSB +: cocu_pkg::CNT_W]);
            compare("receives", want.column, want.receives,
                    data[RECV_LSB +: cocu_pkg::CNT_W]);
            compare("elements", want.column, want.elements,
                    data[ELEM_LSB +: cocu_pkg::CNT_W]);
        endfunction
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cocu_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [cocu_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cocu_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    owner_board_t              board;
    logic [cocu_pkg::ID_W-1:0] entry_ids [$];
    int                        items_sent    = 0;
    bit                        quiet         = 1'b0;
    int                        col_count [4] = '{0, 0, 0, 0};
    int                        overflow_cols = 0;

    column_owner_comm_update #(.PROCS(NPROC)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 LIMIT, board.expected.size());
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    // Result side back-pressure: random stalls until the closing stretch of the run.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic push_entry(input cocu_pkg::action_t act,
                              input logic [cocu_pkg::COL_W-1:0] col,
                              input logic [cocu_pkg::ID_W-1:0] own,
                              input logic [cocu_pkg::ID_W-1:0] pid,
                              input logic last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(cocu_pkg::IN_DATA_W-cocu_pkg::COL_W-2*cocu_pkg::ID_W){1'b0}},
                          pid, own, col};
        s_axis_tuser  <= act;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_entry(act, col, own, pid, last);
        items_sent++;
        quiet = (items_sent >= ITEMS - QUIET_ITEMS);
    endtask

    // Sends entry_ids as one column. With scramble set, the header fields of the
    // earlier transactions carry noise, since only the final one counts.
    task automatic send_column(input cocu_pkg::action_t act,
                               input logic [cocu_pkg::COL_W-1:0] col,
                               input logic [cocu_pkg::ID_W-1:0] own, input bit scramble);
        int i;
        int n;
        n = entry_ids.size();
        for (i = 0; i < n; i++)
        begin
            if (scramble && i != n - 1)
                push_entry(cocu_pkg::action_t'($urandom_range(0, 3)),
                           cocu_pkg::COL_W'($urandom), cocu_pkg::ID_W'($urandom),
                           entry_ids[i], 1'b0);
            else
                push_entry(act, col, own, entry_ids[i], i == n - 1);
        end
        col_count[act]++;
        if (n > cocu_pkg::LIST_CAP)
            overflow_cols++;
    endtask

    initial
    begin
        int                        n;
        int                        pick;
        int                        i;
        logic [cocu_pkg::ID_W-1:0] hot;
        cocu_pkg::action_t         act;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        entry_ids = '{4'd0};
        send_column(cocu_pkg::ACT_GREEDY, '0, 4'd15, 1'b0);
        // Repeated processor and a tie between the two candidates.
        entry_ids = '{4'd3, 4'd5, 4'd3};
        send_column(cocu_pkg::ACT_GREEDY, '1, 4'd0, 1'b0);
        entry_ids = '{4'd15, 4'd2};
        send_column(cocu_pkg::ACT_ASSIGN, 20'h5A5A5, 4'd15, 1'b0);
        entry_ids = '{4'd1};
        send_column(cocu_pkg::ACT_ASSIGN, 20'hA5A5A, 4'd7, 1'b0);
        // Removing from a processor that owns nothing must stop at zero.
        entry_ids = '{4'd4};
        send_column(cocu_pkg::ACT_REMOVE, 20'h00001, 4'd9, 1'b0);
        entry_ids = '{4'd2, 4'd15};
        send_column(cocu_pkg::ACT_REMOVE, 20'h00003, 4'd15, 1'b0);
        entry_ids = '{4'd6};
        send_column(cocu_pkg::ACT_NONE, 20'h00002, 4'd6, 1'b0);
        // Seventeen entries: the last one overruns the list and is dropped.
        entry_ids.delete();
        for (i = 0; i < cocu_pkg::LIST_CAP; i++)
            entry_ids.push_back(cocu_pkg::ID_W'(cocu_pkg::LIST_CAP - 1 - i));
        entry_ids.push_back(4'd7);
        send_column(cocu_pkg::ACT_GREEDY, 20'h80000, 4'd3, 1'b0);

        while (items_sent < ITEMS)
        begin
            if ($urandom_range(0, 24) == 0)
                n = $urandom_range(cocu_pkg::LIST_CAP + 1, cocu_pkg::LIST_CAP + 4);
            else
                n = $urandom_range(1, $urandom_range(1, cocu_pkg::LIST_CAP));
            hot = cocu_pkg::ID_W'($urandom);
            entry_ids.delete();
            repeat (n)
                entry_ids.push_back(($urandom_range(0, 3) == 0) ? hot
                                                                : cocu_pkg::ID_W'($urandom));
            pick = $urandom_range(0, 19);
            act  = (pick < 8) ? cocu_pkg::ACT_GREEDY : (pick < 13) ? cocu_pkg::ACT_ASSIGN :
                   (pick < 18) ? cocu_pkg::ACT_REMOVE : cocu_pkg::ACT_NONE;
            send_column(act, cocu_pkg::COL_W'($urandom), cocu_pkg::ID_W'($urandom),
                        $urandom_range(0, 3) == 0);
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d columns: %0d greedy, %0d assign, %0d remove, %0d unused action.",
                 col_count[0] + col_count[1] + col_count[2] + col_count[3],
                 col_count[cocu_pkg::ACT_GREEDY], col_count[cocu_pkg::ACT_ASSIGN],
                 col_count[cocu_pkg::ACT_REMOVE], col_count[cocu_pkg::ACT_NONE]);
        $display("%0d transactions in, %0d columns overran the list, %0d results compared.",
                 items_sent, overflow_cols, board.checked);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
